// ----- sv/prsv_pkg.sv -----
`timescale 1ns / 1ps

package prsv_pkg;

    typedef enum logic [2:0] {
        OP_CPU_WRITE  = 3'd0,
        OP_CPU_READ   = 3'd1,
        OP_INC_X      = 3'd2,
        OP_INC_Y      = 3'd3,
        OP_COPY_HORIZ = 3'd4,
        OP_COPY_VERT  = 3'd5,
        OP_VBLANK     = 3'd6,
        OP_PRERENDER  = 3'd7
    } t_opcode;

    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_SPR_ADR = 3'd3;
    localparam logic [2:0] REG_SPR_DAT = 3'd4;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDRESS = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        SP_CART,
        SP_NAMETABLE,
        SP_PALETTE
    } t_space;

    typedef struct packed {
        logic [2:0] opcode;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] cartridge_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [14:0] vram_address;
        logic        cart_write;
        logic [12:0] cart_address;
        logic [7:0]  cart_data;
        logic        nmi_request;
    } t_out_req;

    function automatic t_space space_of(input logic [13:0] a);
        t_space s;
        if (a < 14'h2000) begin
            s = SP_CART;
        end else if (a < 14'h3F00) begin
            s = SP_NAMETABLE;
        end else begin
            s = SP_PALETTE;
        end
        return s;
    endfunction

endpackage

// ----- sv/prsv_mem.sv -----
`timescale 1ns / 1ps

module prsv_mem #(
    parameter int NAMETABLE_BYTES = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_mirroring_mode,
    input  logic [13:0]                        i_rd_addr,
    input  logic [13:0]                        i_rd_addr_b,
    input  logic                               i_wr_en,
    input  logic [13:0]                        i_wr_addr,
    input  logic [7:0]                         i_wr_data,
    output logic [7:0]                         o_nt_data,
    output logic [7:0]                         o_pal_data,
    output logic                               o_clear_busy
);
    import prsv_pkg::*;

    localparam int IW = $clog2(NAMETABLE_BYTES);

    logic [7:0]  r_nt [NAMETABLE_BYTES];
    logic [7:0]  r_pal [32];
    logic [31:0] r_pal_valid;
    logic [IW:0] r_clr;
    logic        r_busy;

    function automatic logic [IW-1:0] nt_idx(input logic [13:0] a, input logic m);
        logic [10:0] i;
        i = m ? a[10:0] : {a[11], a[9:0]};
        return IW'(i);
    endfunction

    logic [4:0] pal_rd_idx;
    logic [4:0] pal_wr_idx;
    logic [IW-1:0] nt_wr_idx;

    always_comb begin
        pal_rd_idx = (i_rd_addr[1:0] == 2'b00) ? 5'd0 : i_rd_addr[4:0];
        pal_wr_idx = i_wr_addr[4:0];
        if (pal_wr_idx[4] && pal_wr_idx[1:0] == 2'b00) begin
            pal_wr_idx[4] = 1'b0;
        end
        nt_wr_idx = r_busy ? r_clr[IW-1:0] : nt_idx(i_wr_addr, i_mirroring_mode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_busy      <= 1'b1;
            r_pal_valid <= '0;
        end else begin
            if (r_busy) begin
                r_clr <= r_clr + (IW+1)'(1);
                if (r_clr == (IW+1)'(NAMETABLE_BYTES - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_wr_en && space_of(i_wr_addr) == SP_PALETTE) begin
                r_pal_valid[pal_wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy || (i_wr_en && space_of(i_wr_addr) == SP_NAMETABLE)) begin
            r_nt[nt_wr_idx] <= r_busy ? 8'h00 : i_wr_data;
        end
        o_nt_data <= r_nt[nt_idx(i_rd_addr_b, i_mirroring_mode)];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && space_of(i_wr_addr) == SP_PALETTE) begin
            r_pal[pal_wr_idx] <= i_wr_data;
        end
        o_pal_data <= r_pal_valid[pal_rd_idx] ? r_pal[pal_rd_idx] : 8'h00;
    end

    assign o_clear_busy = r_busy;

endmodule

// ----- sv/ppu_register_port_scroll_vram_core.sv -----
`timescale 1ns / 1ps
// Flow: an accepted request is captured in r_in and the state moves to ST_EXEC, where the
// result is computed; it is registered into r_out as the state enters ST_OUT, raising o_valid.
// The state machine keeps one request in flight: it takes, executes and hands off each request
// before it accepts the next, and a stalled output holds the result in ST_OUT.
// Reset: synchronous, active low. After reset a clearing pass writes zero to each
// nametable entry, while no request is taken.
module ppu_register_port_scroll_vram_core #(
    parameter int NAMETABLE_BYTES = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  prsv_pkg::t_in_req  i_req,
    output logic               o_valid,
    input  logic               i_stall,
    output prsv_pkg::t_out_req o_req
);
    import prsv_pkg::*;

    t_state     r_state, n_state;
    t_in_req    r_in;
    logic       r_mirror;
    logic [14:0] r_v, n_v, r_t, n_t;
    logic [2:0] r_fx, n_fx;
    logic       r_w, n_w;
    logic [7:0] r_ctrl, n_ctrl, r_mask, n_mask, r_stat, n_stat;
    logic [7:0] r_oam_a, n_oam_a, r_oam_d, n_oam_d, r_buf, n_buf;
    t_out_req   r_out, n_out;

    logic [7:0] nt_data, pal_data;
    logic       clear_busy;
    logic       wr_en;
    logic [13:0] a14, a_b;
    logic        accept, take;

    assign a14 = r_v[13:0];
    assign a_b = (space_of(a14) == SP_PALETTE) ? a14 - 14'h1000 : a14;

    prsv_mem #(.NAMETABLE_BYTES(NAMETABLE_BYTES)) u_mem (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mirroring_mode(r_mirror),
        .i_rd_addr       (a14),
        .i_rd_addr_b     (a_b),
        .i_wr_en         (wr_en),
        .i_wr_addr       (a14),
        .i_wr_data       (r_in.write_data),
        .o_nt_data       (nt_data),
        .o_pal_data      (pal_data),
        .o_clear_busy    (clear_busy)
    );

    assign o_stall = (r_state != ST_IDLE) || clear_busy;
    assign accept  = i_valid && !o_stall;
    assign o_valid = (r_state == ST_OUT);
    assign take    = o_valid && !i_stall;
    assign o_req   = r_out;
    assign wr_en   = (r_state == ST_EXEC) && r_in.opcode == OP_CPU_WRITE
                     && r_in.reg_index == REG_DATA;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_OUT;
            ST_OUT:  if (take) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    logic        render;
    logic [14:0] inc_v, vx, vy;
    logic [4:0]  cy;
    logic [7:0]  d, mem_b;

    always_comb begin
        d      = r_in.write_data;
        render = (r_mask[4:3] != 2'b00);
        inc_v  = {1'b0, 14'(r_v[13:0] + (r_ctrl[2] ? 14'd32 : 14'd1))};
        vx = (r_v[4:0] == 5'd31) ? ((r_v & ~15'h001F) ^ 15'h0400) : r_v + 15'd1;
        vy = r_v;
        cy = r_v[9:5];
        if (r_v[14:12] != 3'b111) begin
            vy = r_v + 15'h1000;
        end else begin
            vy[14:12] = 3'b000;
            cy = r_v[9:5];
            if (cy == 5'd29) begin
                cy = 5'd0;
                vy[11] = ~vy[11];
            end else if (cy == 5'd31) begin
                cy = 5'd0;
            end else begin
                cy = cy + 5'd1;
            end
            vy[9:5] = cy;
        end
        case (space_of(a_b))
            SP_CART: mem_b = r_in.cartridge_byte;
            default: mem_b = nt_data;
        endcase
    end

    always_comb begin
        n_v = r_v; n_t = r_t; n_fx = r_fx; n_w = r_w;
        n_ctrl = r_ctrl; n_mask = r_mask; n_stat = r_stat;
        n_oam_a = r_oam_a; n_oam_d = r_oam_d; n_buf = r_buf;
        n_out = r_out;
        if (r_state == ST_OUT && !take) begin
            n_out = r_out;
        end else if (r_state == ST_OUT || r_state == ST_IDLE) begin
            n_out = r_out;
        end else begin
            n_out = '0;
            case (t_opcode'(r_in.opcode))
                OP_CPU_WRITE: begin
                    case (r_in.reg_index)
                        REG_CONTROL: begin
                            n_t = (r_t & 15'h73FF) | {3'b000, d[1:0], 10'h000};
                            n_ctrl = d;
                        end
                        REG_MASK:    n_mask = d;
                        REG_STATUS:  n_stat = {r_stat[7], d[6:0]};
                        REG_SPR_ADR: n_oam_a = d;
                        REG_SPR_DAT: n_oam_d = d;
                        REG_SCROLL: begin
                            if (!r_w) begin
                                n_t = (r_t & 15'h7FE0) | {10'h000, d[7:3]};
                                n_fx = d[2:0];
                                n_w = 1'b1;
                            end else begin
                                n_t = (r_t & 15'h0C1F) | {d[2:0], 2'b00, d[7:3], 5'h00};
                                n_w = 1'b0;
                            end
                        end
                        REG_ADDRESS: begin
                            if (!r_w) begin
                                n_t = {1'b0, d[5:0], r_t[7:0]};
                                n_w = 1'b1;
                            end else begin
                                n_t = {r_t[14:8], d};
                                n_v = n_t;
                                n_w = 1'b0;
                            end
                        end
                        default: begin
                            if (space_of(a14) == SP_CART) begin
                                n_out.cart_write   = 1'b1;
                                n_out.cart_address = a14[12:0];
                                n_out.cart_data    = d;
                            end
                            n_v = inc_v;
                        end
                    endcase
                end
                OP_CPU_READ: begin
                    case (r_in.reg_index)
                        REG_STATUS: begin
                            n_out.read_data = r_stat;
                            n_stat = {1'b0, r_stat[6:0]};
                            n_w = 1'b0;
                        end
                        REG_SPR_DAT: n_out.read_data = r_oam_d;
                        REG_DATA: begin
                            n_out.read_data = (space_of(a14) == SP_PALETTE) ? pal_data : r_buf;
                            n_buf = mem_b;
                            n_v = inc_v;
                        end
                        default: n_out.read_data = 8'h00;
                    endcase
                end
                OP_INC_X:      if (render) n_v = vx;
                OP_INC_Y:      if (render) n_v = vy;
                OP_COPY_HORIZ: if (render) n_v = (r_v & ~15'h041F) | (r_t & 15'h041F);
                OP_COPY_VERT:  if (render) n_v = (r_v & ~15'h7BE0) | (r_t & 15'h7BE0);
                OP_VBLANK: begin
                    n_stat = r_stat | 8'h80;
                    n_out.nmi_request = r_ctrl[7];
                end
                default: n_stat = r_stat & 8'h1F;
            endcase
            n_out.vram_address = n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mirror <= 1'b0;
            r_v <= '0; r_t <= '0; r_fx <= '0; r_w <= 1'b0;
            r_ctrl <= '0; r_mask <= '0; r_stat <= '0;
            r_oam_a <= '0; r_oam_d <= '0; r_buf <= '0;
            r_out <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mirror <= i_cfg_data;
            end
            r_v <= n_v; r_t <= n_t; r_fx <= n_fx; r_w <= n_w;
            r_ctrl <= n_ctrl; r_mask <= n_mask; r_stat <= n_stat;
            r_oam_a <= n_oam_a; r_oam_d <= n_oam_d; r_buf <= n_buf;
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_req;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !accept) else $error("request taken while busy");
    a_exec_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> (r_state == ST_OUT)) else $error("exec did not finish");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_req))) else $error("result lost");
    a_cart_only_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_req.cart_write) |-> (o_req.read_data == 8'h00))
        else $error("cart write with read data");
`endif

endmodule
